@@ hdl/fix_message_validator_macros.svh @@
// Assertion macros for the FIX message validator.
// No dependencies; included by the top level.
`ifndef FIX_MESSAGE_VALIDATOR_MACROS_SVH
`define FIX_MESSAGE_VALIDATOR_MACROS_SVH
`ifndef SYNTH
`define FMV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FMV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMV_ASSERT(label, clk, rst, prop, msg)
`define FMV_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/fmv_pkg.sv @@
// Shared types and constants of the FIX message validator.
// No dependencies.
`default_nettype none
package fmv_pkg;
   localparam int POSITION_BITS = 16;
   localparam int PB1 = POSITION_BITS + 1;
   localparam logic [PB1-1:0] POS_LIMIT = PB1'(1) << POSITION_BITS;
   localparam logic [PB1-1:0] LEN_SAT = '1;
   localparam logic [7:0] SOH_BYTE = 8'h01;
   localparam logic [31:0] TAG_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] TAG_OVER = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_T8, ST_V8, ST_T9, ST_V9, ST_BT, ST_BV, ST_CT, ST_CV, ST_DONE, ST_ERR
   } stage_type;

   localparam logic [3:0] E_OK = 4'd0, E_MISS8 = 4'd1, E_BAD8 = 4'd2, E_MISS9 = 4'd3,
      E_BAD9 = 4'd4, E_NEG9 = 4'd5, E_EXCEED = 4'd6, E_BODY = 4'd7, E_MISS10 = 4'd8,
      E_SUM = 4'd9, E_MSGTYPE = 4'd10, E_LONG = 4'd11;

   typedef struct packed {
      logic        kind;
      logic [3:0]  code;
      logic [30:0] tag;
      logic [15:0] offset;
      logic [15:0] length;
      logic [7:0]  sum;
      logic        last;
   } record_type;

   // Work handed from the front to the back: up to two records of one byte.
   typedef struct packed {
      logic       has_field;
      logic       has_status;
      record_type field_rec;
      record_type status_rec;
   } job_type;

   function automatic logic [7:0] begin_char(input logic [2:0] i);
      case (i)
         3'd0: return "F";
         3'd1: return "I";
         3'd2: return "X";
         3'd3: return ".";
         3'd4: return "4";
         3'd5: return ".";
         3'd6: return "2";
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [31:0] tag_digit(input logic [31:0] acc, input logic [3:0] d);
      logic [35:0] t;
      t = {acc, 3'b000} + {2'b00, acc, 1'b0} + 36'(d);
      return (acc > 32'd214748364 || t > 36'(TAG_MAX)) ? TAG_OVER : t[31:0];
   endfunction
endpackage
`default_nettype wire

@@ hdl/fix_message_validator.sv @@
// Top level of the FIX 4.2 message validator: front, queue, back.
// Depends on fmv_pkg, fmv_front, fmv_queue, fmv_back and the macro header.
//   channel   direction  words
//   req_      in         data_byte, final_byte
//   rsp_      out        one record per word
// One byte is taken each cycle while the four-entry queue has room.
// A byte yields zero, one or two records; two are emitted one after the other.
// Reset is synchronous and clears the parser and the queue pointers.
// Output stalls fill the queue and then hold req_ready low.
`default_nettype none
`include "fix_message_validator_macros.svh"
module fix_message_validator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_record_kind,
   output logic [3:0]       rsp_status_code,
   output logic [30:0]      rsp_field_tag,
   output logic [15:0]      rsp_value_offset,
   output logic [15:0]      rsp_value_length,
   output logic [7:0]       rsp_computed_sum,
   output logic             rsp_run_end
);
   import fmv_pkg::*;

   job_type fjob, qhead;
   record_type rec;
   logic fvalid, space, nonempty, pop;

   fmv_front u_front (.clock, .reset, .req_valid, .req_ready, .req_data_byte,
      .req_final_byte, .job_valid(fvalid), .job(fjob), .job_space(space));
   fmv_queue u_queue (.clock, .reset, .push(fvalid), .push_job(fjob), .space,
      .not_empty(nonempty), .head(qhead), .pop);
   fmv_back u_back (.clock, .reset, .job_valid(nonempty), .job(qhead), .job_pop(pop),
      .out_valid(rsp_valid), .out_rec(rec), .out_ready(rsp_ready));

   assign rsp_record_kind = rec.kind;
   assign rsp_status_code = rec.code;
   assign rsp_field_tag = rec.tag;
   assign rsp_value_offset = rec.offset;
   assign rsp_value_length = rec.length;
   assign rsp_computed_sum = rec.sum;
   assign rsp_run_end = rec.last;

   `FMV_ASSERT(a_ready_space, clock, reset, req_ready == space, "ready without space")
   `FMV_ASSERT(a_end_status, clock, reset, rsp_valid |-> (rsp_run_end == rsp_record_kind),
      "run end mismatch")
   `FMV_ASSERT(a_pop_nonempty, clock, reset, pop |-> nonempty, "pop of empty queue")
endmodule
`default_nettype wire

@@ hdl/fmv_front.sv @@
// Front end: parses one byte per cycle while the queue has room and forms the records it causes.
// Depends on fmv_pkg.
`default_nettype none
module fmv_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [7:0]      req_data_byte,
   input  wire logic            req_final_byte,
   output logic                 job_valid,
   output fmv_pkg::job_type     job,
   input  wire logic            job_space
);
   import fmv_pkg::*;

   stage_type stage_ff, stage_in;
   logic [PB1-1:0] pos_ff, pos_in, bend_ff, bend_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] vstart_ff, vstart_in;
   logic [7:0] sum_ff, sum_in;
   logic [2:0] midx_ff, midx_in;
   logic [3:0] err_ff, err_in, flags_ff, flags_in, fcode;
   logic mt_ff, mt_in, known_ff, known_in;
   logic [7:0] b;
   logic isdig, go;
   logic [3:0] dv, cdig;
   logic [PB1-1:0] npos;
   logic [PB1+1:0] dsum;
   logic [35:0] lt;
   logic [15:0] dlen;
   logic [7:0] rem100;
   logic [1:0] hund;
   logic [14:0] tmul;
   logic [3:0] tens;

   assign req_ready = job_space;
   assign go = req_valid && req_ready;
   assign b = req_data_byte;
   assign isdig = b >= "0" && b <= "9";
   assign dv = b[3:0] - 4'd0;

   // Decimal digits of the running sum; tens come from a multiply by 205 and a shift.
   always_comb begin
      if (sum_ff >= 8'd200) begin
         hund = 2'd2; rem100 = sum_ff - 8'd200;
      end else if (sum_ff >= 8'd100) begin
         hund = 2'd1; rem100 = sum_ff - 8'd100;
      end else begin
         hund = 2'd0; rem100 = sum_ff;
      end
      tmul = 15'(rem100) * 15'd205;
      tens = tmul[14:11];
      case (midx_ff)
         3'd0: cdig = {2'b00, hund};
         3'd1: cdig = tens;
         default: cdig = 4'(rem100 - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0});
      endcase
   end

   always_comb begin
      stage_in = stage_ff; pos_in = pos_ff; bend_in = bend_ff; acc_in = acc_ff;
      vstart_in = vstart_ff; sum_in = sum_ff; midx_in = midx_ff; err_in = err_ff;
      flags_in = flags_ff; mt_in = mt_ff; known_in = known_ff;
      job = '0;
      dsum = '0; lt = '0; dlen = '0; fcode = E_OK; npos = '0;
      if (pos_ff >= POS_LIMIT && err_ff != E_LONG) begin
         err_in = E_LONG; stage_in = ST_ERR;
      end
      if ((stage_in == ST_BT || stage_in == ST_BV) && pos_ff >= bend_ff) begin
         if (stage_in == ST_BT && !flags_in[0]) begin
            stage_in = ST_CT; acc_in = '0; flags_in = '0; midx_in = '0;
         end else begin
            err_in = E_BODY; stage_in = ST_ERR;
         end
      end
      if (!known_ff || pos_ff < bend_ff) sum_in = sum_ff + b;
      case (stage_in)
         ST_T8, ST_T9, ST_CT: begin
            if (isdig) begin
               acc_in = tag_digit(acc_in, dv); flags_in[0] = 1'b1;
            end else if (b == "=" && flags_in[0] &&
                         acc_in == (stage_in == ST_T8 ? 32'd8 :
                                    stage_in == ST_T9 ? 32'd9 : 32'd10)) begin
               stage_in = stage_type'(stage_in + 4'd1);
               acc_in = '0; flags_in = '0; midx_in = '0;
            end else begin
               err_in = stage_in == ST_T8 ? E_MISS8 : stage_in == ST_T9 ? E_MISS9 : E_MISS10;
               stage_in = ST_ERR;
            end
         end
         ST_V8: begin
            if (b == SOH_BYTE) begin
               if (flags_in[1] || midx_in != 3'd7) begin
                  err_in = E_BAD8; stage_in = ST_ERR;
               end else begin
                  stage_in = ST_T9; acc_in = '0; flags_in = '0; midx_in = '0;
               end
            end else if (midx_in == 3'd7) flags_in[1] = 1'b1;
            else begin
               if (b != begin_char(midx_in)) flags_in[1] = 1'b1;
               midx_in = midx_in + 3'd1;
            end
         end
         ST_V9: begin
            if (b == SOH_BYTE) begin
               if (!flags_in[0]) begin
                  err_in = E_BAD9; stage_in = ST_ERR;
               end else if (flags_in[2] && acc_in != 0) begin
                  err_in = E_NEG9; stage_in = ST_ERR;
               end else begin
                  dsum = (PB1+2)'(pos_ff) + 1'b1 + (PB1+2)'(acc_in[PB1-1:0]);
                  bend_in = dsum > (PB1+2)'(LEN_SAT) ? LEN_SAT : dsum[PB1-1:0];
                  known_in = 1'b1;
                  stage_in = ST_BT; acc_in = '0; flags_in = '0; midx_in = '0;
               end
            end else if (flags_in[3]) begin
            end else if (isdig) begin
               lt = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0} + 36'(dv);
               acc_in = lt > 36'(LEN_SAT) ? 32'(LEN_SAT) : lt[31:0];
               flags_in[0] = 1'b1;
            end else if (b == "-" && !flags_in[0] && !flags_in[2]) flags_in[2] = 1'b1;
            else flags_in[3] = 1'b1;
         end
         ST_BT: begin
            if (isdig) begin
               acc_in = tag_digit(acc_in, dv); flags_in[0] = 1'b1;
            end else if (b == "=" && flags_in[0] && acc_in != TAG_OVER) begin
               vstart_in = 16'(pos_ff + 1'b1); stage_in = ST_BV;
            end else begin
               err_in = E_BODY; stage_in = ST_ERR;
            end
         end
         ST_BV: begin
            if (b == SOH_BYTE) begin
               dlen = 16'(pos_ff) - vstart_ff;
               if (acc_in == 32'd35) mt_in = dlen != 0;
               job.has_field = 1'b1;
               job.field_rec.tag = acc_in[30:0];
               job.field_rec.offset = vstart_ff;
               job.field_rec.length = dlen;
               stage_in = ST_BT; acc_in = '0; flags_in = '0; midx_in = '0;
            end
         end
         ST_CV: begin
            if (b == SOH_BYTE) begin
               if (flags_in[1] || midx_in != 3'd3) begin
                  err_in = E_SUM; stage_in = ST_ERR;
               end else stage_in = ST_DONE;
            end else if (midx_in >= 3'd3) flags_in[1] = 1'b1;
            else begin
               if (b != (8'h30 | 8'(cdig))) flags_in[1] = 1'b1;
               midx_in = midx_in + 3'd1;
            end
         end
         default: begin
         end
      endcase
      npos = pos_ff < POS_LIMIT ? pos_ff + 1'b1 : pos_ff;
      pos_in = npos;
      if (err_in == E_LONG) fcode = E_LONG;
      else if (err_in >= E_MISS8 && err_in <= E_NEG9) fcode = err_in;
      else if (stage_in == ST_T8 || stage_in == ST_V8) fcode = E_MISS8;
      else if (stage_in == ST_T9 || stage_in == ST_V9) fcode = E_MISS9;
      else if (bend_in > npos) fcode = E_EXCEED;
      else if (err_in != E_OK) fcode = err_in;
      else if (stage_in == ST_BT) fcode = flags_in[0] ? E_BODY : E_MISS10;
      else if (stage_in == ST_BV) fcode = E_BODY;
      else if (stage_in == ST_CT || stage_in == ST_CV) fcode = E_MISS10;
      else fcode = mt_in ? E_OK : E_MSGTYPE;
      if (req_final_byte) begin
         job.has_status = 1'b1;
         job.status_rec.kind = 1'b1;
         job.status_rec.code = fcode;
         job.status_rec.sum = sum_in;
         job.status_rec.last = 1'b1;
         stage_in = ST_T8; pos_in = '0; bend_in = '0; acc_in = '0; vstart_in = '0;
         sum_in = '0; midx_in = '0; err_in = '0; flags_in = '0; mt_in = 1'b0;
         known_in = 1'b0;
      end
   end

   assign job_valid = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_T8; pos_ff <= '0; bend_ff <= '0; acc_ff <= '0; vstart_ff <= '0;
         sum_ff <= '0; midx_ff <= '0; err_ff <= '0; flags_ff <= '0; mt_ff <= 1'b0;
         known_ff <= 1'b0;
      end else if (go) begin
         stage_ff <= stage_in; pos_ff <= pos_in; bend_ff <= bend_in; acc_ff <= acc_in;
         vstart_ff <= vstart_in; sum_ff <= sum_in; midx_ff <= midx_in; err_ff <= err_in;
         flags_ff <= flags_in; mt_ff <= mt_in; known_ff <= known_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/fmv_queue.sv @@
// Short job queue between front and back, four entries in flip-flops.
// Depends on fmv_pkg.
`default_nettype none
module fmv_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire fmv_pkg::job_type push_job,
   output logic                 space,
   output logic                 not_empty,
   output fmv_pkg::job_type     head,
   input  wire logic            pop
);
   import fmv_pkg::*;

   job_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign space = cnt_ff != 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule
`default_nettype wire

@@ hdl/fmv_back.sv @@
// Back end: emits the field record, if any, and then the status record, if any, of each job.
// Depends on fmv_pkg.
`default_nettype none
module fmv_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            job_valid,
   input  wire fmv_pkg::job_type job,
   output logic                 job_pop,
   output logic                 out_valid,
   output fmv_pkg::record_type  out_rec,
   input  wire logic            out_ready
);
   import fmv_pkg::*;

   logic done_field_ff, done_field_in;
   logic live, take, want_field;

   assign live = job_valid && (job.has_field || job.has_status);
   assign want_field = job.has_field && !done_field_ff;
   assign out_valid = live;
   assign out_rec = want_field ? job.field_rec : job.status_rec;
   assign take = out_valid && out_ready;
   assign job_pop = job_valid && (!live || (take && !(want_field && job.has_status)));
   assign done_field_in = take && want_field && job.has_status;

   always_ff @(posedge clock) begin
      if (reset) done_field_ff <= 1'b0;
      else if (job_pop) done_field_ff <= 1'b0;
      else if (done_field_in) done_field_ff <= 1'b1;
   end
endmodule
`default_nettype wire
